### hdl/bapr_pkg.sv
// ----------------------------------------------------------------------------
// bapr_pkg: shared definitions for the bit-aligned pattern replacer
// Sizes, register indexes, control structs and the pattern length mask.
// ----------------------------------------------------------------------------
package bapr_pkg;

  localparam int MAX_PATTERN_BYTES = 8;
  localparam int COUNT_BITS        = 16;

  localparam int PAT_BITS   = 8 * MAX_PATTERN_BYTES;
  localparam int SCAN_BYTES = MAX_PATTERN_BYTES + 1;
  localparam int SCAN_BITS  = 8 * SCAN_BYTES;
  // One spare cell beyond the scan window lets a new byte enter while a pop waits.
  localparam int NUM_CELLS  = MAX_PATTERN_BYTES + 2;
  localparam int FILL_W     = $clog2(NUM_CELLS + 1);
  localparam int LEN_W      = $clog2(MAX_PATTERN_BYTES + 1);
  localparam int SHIFT_W    = $clog2(PAT_BITS + 1);
  localparam int SKIP_W     = $clog2(PAT_BITS);

  localparam int REG_W     = 64;
  localparam int CFG_LEN_W = 4;
  localparam int ADDR_W    = 5;
  localparam int RC_W      = 16;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [1:0] {
    REG_PATTERN = 2'd0,
    REG_REPLACE = 2'd1,
    REG_LENGTH  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [PAT_BITS-1:0] pat_bits;
    logic [PAT_BITS-1:0] rep_bits;
    logic [LEN_W-1:0]    len;
    logic                active;
  } cfg_t;

  typedef struct packed {
    logic pop;
    logic load;
  } cell_ctl_t;

  typedef struct packed {
    logic                 hit;
    logic [2:0]           off;
    logic [SCAN_BITS-1:0] mask;
    logic [SCAN_BITS-1:0] bits;
    logic [SKIP_W-1:0]    skip_nxt;
  } match_t;

  // Ones in the low 8*len bits of a pattern-wide word.
  function automatic logic [PAT_BITS-1:0] len_mask(input logic [LEN_W-1:0] len);
    logic [SHIFT_W-1:0] sh;
    sh = SHIFT_W'(PAT_BITS) - SHIFT_W'({len, 3'b000});
    return {PAT_BITS{1'b1}} >> sh;
  endfunction

endpackage

### hdl/bapr_in_if.sv
// ----------------------------------------------------------------------------
// bapr_in_if: input byte stream channel
// Valid/ready channel carrying one stream byte and its last mark.
// ----------------------------------------------------------------------------
interface bapr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, in_byte, in_last, input ready);
  modport sink   (input valid, in_byte, in_last, output ready);
endinterface

### hdl/bapr_out_if.sv
// ----------------------------------------------------------------------------
// bapr_out_if: output byte stream channel
// Valid/ready channel carrying one output byte, last mark and replacement count.
// ----------------------------------------------------------------------------
interface bapr_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        out_last;
  logic [15:0] replace_count;

  modport source (output valid, out_byte, out_last, replace_count, input ready);
  modport sink   (input valid, out_byte, out_last, replace_count, output ready);
endinterface

### hdl/bapr_cfg.sv
// ----------------------------------------------------------------------------
// bapr_cfg: configuration registers
// APB-style register file for pattern, replacement and pattern length.
// ----------------------------------------------------------------------------
module bapr_cfg import bapr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [REG_W-1:0]  pwdata,
  output logic [REG_W-1:0]  prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [REG_W-1:0]     pattern_r, pattern_nxt;
  logic [REG_W-1:0]     replace_r, replace_nxt;
  logic [CFG_LEN_W-1:0] length_r, length_nxt;
  logic                 wr_en;
  reg_idx_t             idx;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    pattern_nxt = pattern_r;
    replace_nxt = replace_r;
    length_nxt  = length_r;
    if (wr_en) begin
      case (idx)
        REG_PATTERN: pattern_nxt = pwdata;
        REG_REPLACE: replace_nxt = pwdata;
        REG_LENGTH:  length_nxt  = pwdata[CFG_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PATTERN: prdata = pattern_r;
      REG_REPLACE: prdata = replace_r;
      REG_LENGTH:  prdata = REG_W'(length_r);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      replace_r <= '0;
      length_r  <= CFG_LEN_W'(1);
    end else begin
      pattern_r <= pattern_nxt;
      replace_r <= replace_nxt;
      length_r  <= length_nxt;
    end
  end

  // A length of zero behaves as one, anything beyond the maximum as the maximum.
  always_comb begin
    cfg.pat_bits = pattern_r[PAT_BITS-1:0];
    cfg.rep_bits = replace_r[PAT_BITS-1:0];
    if (length_r == '0) begin
      cfg.len = LEN_W'(1);
    end else if (length_r > CFG_LEN_W'(MAX_PATTERN_BYTES)) begin
      cfg.len = LEN_W'(MAX_PATTERN_BYTES);
    end else begin
      cfg.len = LEN_W'(length_r);
    end
    cfg.active = |((cfg.pat_bits ^ cfg.rep_bits) & len_mask(cfg.len));
  end

endmodule

### hdl/bapr_cell.sv
// ----------------------------------------------------------------------------
// bapr_cell: one byte of the stream window
// Holds a byte, applies its slice of a replacement, and shifts toward the head.
// ----------------------------------------------------------------------------
module bapr_cell import bapr_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic [7:0] in_byte,
  input  logic [7:0] nbr_byte,
  input  logic [7:0] rep_mask,
  input  logic [7:0] rep_bits,
  output logic [7:0] cur_byte,
  output logic [7:0] mod_byte
);

  logic [7:0] byte_r, byte_nxt;

  assign cur_byte = byte_r;
  assign mod_byte = (byte_r & ~rep_mask) | (rep_bits & rep_mask);

  // A byte loaded into a cell wins over the shift, since that slot was empty.
  always_comb begin
    if (ctl.load) begin
      byte_nxt = in_byte;
    end else if (ctl.pop) begin
      byte_nxt = nbr_byte;
    end else begin
      byte_nxt = byte_r;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

endmodule

### hdl/bapr_match.sv
// ----------------------------------------------------------------------------
// bapr_match: head byte scanner
// Eight offset comparators pick the first uncovered bit start of the head byte.
// ----------------------------------------------------------------------------
module bapr_match import bapr_pkg::*; (
  input  logic [SCAN_BITS-1:0] win,
  input  logic [FILL_W-1:0]    fill,
  input  logic [SKIP_W-1:0]    skip,
  input  cfg_t                 cfg,
  output match_t               m
);

  logic [PAT_BITS-1:0] lmask;
  logic [SHIFT_W-1:0]  sk;
  logic                has_len;
  logic                has_len1;
  logic [7:0]          cand;

  always_comb begin
    lmask    = len_mask(cfg.len);
    sk       = SHIFT_W'(skip);
    has_len  = fill >= FILL_W'(cfg.len);
    has_len1 = fill > FILL_W'(cfg.len);
    for (int k = 0; k < 8; k++) begin
      cand[k] = cfg.active && (SHIFT_W'(k) >= sk) && ((k == 0) ? has_len : has_len1) &&
                (((win[k +: PAT_BITS] ^ cfg.pat_bits) & lmask) == '0);
    end
  end

  always_comb begin
    m.hit = |cand;
    m.off = '0;
    for (int k = 7; k >= 0; k--) begin
      if (cand[k]) begin
        m.off = 3'(k);
      end
    end
    if (m.hit) begin
      m.mask = SCAN_BITS'(lmask) << m.off;
      m.bits = SCAN_BITS'(cfg.rep_bits & lmask) << m.off;
      // Starts after this one up to the end of the match stay covered.
      m.skip_nxt = SKIP_W'(SHIFT_W'({cfg.len, 3'b000}) - SHIFT_W'(8) + SHIFT_W'(m.off));
    end else begin
      m.mask = '0;
      m.bits = '0;
      m.skip_nxt = (sk >= SHIFT_W'(8)) ? SKIP_W'(sk - SHIFT_W'(8)) : '0;
    end
  end

endmodule

### hdl/bit_aligned_pattern_replace.sv
// ----------------------------------------------------------------------------
// bit_aligned_pattern_replace: bit-aligned pattern replacement on a byte stream
// A row of byte cells shifts the stream past a head scanner that overwrites
// matches of the configured pattern at any bit offset.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the output accepts; a stream's last
//   byte drains the held bytes at one per cycle as accepted; input is held off.
// Output: a byte is registered for the output once the pattern_length-th byte
//   behind it is held and the output is free; at stream end the window drains.
// Reset: synchronous, active low; clears fill, skip, count and handshake state;
//   window cell contents are not cleared.
module bit_aligned_pattern_replace import bapr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  bapr_in_if.sink           in_if,
  bapr_out_if.source        out_if,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [REG_W-1:0]  pwdata,
  output logic [REG_W-1:0]  prdata,
  output logic              pready
);

  cfg_t   cfg;
  match_t m;

  logic [FILL_W-1:0]     fill_r, fill_nxt, fill_after;
  logic [SKIP_W-1:0]     skip_r, skip_nxt;
  logic [COUNT_BITS-1:0] total_r, total_nxt, cnt_now;
  logic                  flush_r, flush_nxt;
  logic                  busy_r, busy_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [7:0]            out_byte_r;
  logic                  out_last_r;
  logic [RC_W-1:0]       out_count_r;

  logic                  in_fire, in_rdy, pop_need, pop, fin, out_free;
  logic [31:0]           cnt_ext;
  logic [SCAN_BITS-1:0]  win;

  cell_ctl_t  ctl     [NUM_CELLS];
  logic [7:0] cur_b   [NUM_CELLS];
  logic [7:0] mod_b   [NUM_CELLS];
  logic [7:0] nbr_b   [NUM_CELLS];
  logic [7:0] rmask_b [NUM_CELLS];
  logic [7:0] rbits_b [NUM_CELLS];

  bapr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bapr_match u_match (
    .win  (win),
    .fill (fill_r),
    .skip (skip_r),
    .cfg  (cfg),
    .m    (m)
  );

  // Handshake and pop control. Pops follow an accepted byte; a config change
  // while idle therefore never releases bytes on its own.
  assign in_rdy     = !flush_r && (fill_r < FILL_W'(NUM_CELLS));
  assign in_fire    = in_if.valid && in_rdy;
  assign out_free   = !out_valid_r || out_if.ready;
  assign pop_need   = busy_r && (flush_r ? (fill_r != '0) : (fill_r > FILL_W'(cfg.len)));
  assign pop        = pop_need && out_free;
  assign fin        = pop && flush_r && (fill_r == FILL_W'(1));
  assign fill_after = fill_r - FILL_W'(pop);

  assign in_if.ready          = in_rdy;
  assign out_if.valid         = out_valid_r;
  assign out_if.out_byte      = out_byte_r;
  assign out_if.out_last      = out_last_r;
  assign out_if.replace_count = out_count_r;

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    always_comb begin
      ctl[i].pop  = pop;
      ctl[i].load = in_fire && (fill_after == FILL_W'(i));
    end

    if (i == NUM_CELLS - 1) begin : g_tail
      assign nbr_b[i] = 8'h00;
    end else begin : g_link
      assign nbr_b[i] = mod_b[i+1];
    end

    if (i < SCAN_BYTES) begin : g_scan
      assign win[8*i +: 8] = cur_b[i];
      assign rmask_b[i]    = pop ? m.mask[8*i +: 8] : 8'h00;
      assign rbits_b[i]    = m.bits[8*i +: 8];
    end else begin : g_spare
      assign rmask_b[i] = 8'h00;
      assign rbits_b[i] = 8'h00;
    end

    bapr_cell u_cell (
      .clk      (clk),
      .ctl      (ctl[i]),
      .in_byte  (in_if.in_byte),
      .nbr_byte (nbr_b[i]),
      .rep_mask (rmask_b[i]),
      .rep_bits (rbits_b[i]),
      .cur_byte (cur_b[i]),
      .mod_byte (mod_b[i])
    );
  end

  always_comb begin
    cnt_now = (m.hit && (total_r != CNT_MAX)) ? total_r + COUNT_BITS'(1) : total_r;
    cnt_ext = 32'(cnt_now);

    fill_nxt  = fill_after + FILL_W'(in_fire);
    skip_nxt  = pop ? m.skip_nxt : skip_r;
    total_nxt = pop ? cnt_now : total_r;
    flush_nxt = flush_r;
    if (in_fire && in_if.in_last) begin
      flush_nxt = 1'b1;
    end
    // The final transfer of a stream returns the scan state to its start.
    if (fin) begin
      flush_nxt = 1'b0;
      skip_nxt  = '0;
      total_nxt = '0;
    end
    busy_nxt      = in_fire || (busy_r && pop_need);
    out_valid_nxt = pop || (out_valid_r && !out_if.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      skip_r      <= '0;
      total_r     <= '0;
      flush_r     <= 1'b0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      skip_r      <= skip_nxt;
      total_r     <= total_nxt;
      flush_r     <= flush_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_byte_r <= mod_b[0];
      out_last_r <= fin;
      if (!fin) begin
        out_count_r <= '0;
      end else if (cnt_ext > 32'h0000_FFFF) begin
        out_count_r <= 16'hFFFF;
      end else begin
        out_count_r <= cnt_ext[RC_W-1:0];
      end
    end
  end

endmodule

### hdl/bapr_checker.sv
// ----------------------------------------------------------------------------
// bapr_checker: port-level checks for the pattern replacer
// Watches the stream channels over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module bapr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic        out_last,
  input logic [15:0] replace_count
);

  // The count is only reported with the final byte of a stream.
  a_count_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> (replace_count == 16'h0000))
    else $error("replace_count nonzero on a byte that is not last");

  // Once a stream's last byte is taken, input waits for the drain.
  a_hold_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_last) |=> !in_ready)
    else $error("input ready right after the last byte of a stream");

  // A stalled output transfer keeps its byte.
  a_out_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_byte) && $stable(out_last)))
    else $error("output changed while stalled");

  // Reset leaves no output pending.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind bit_aligned_pattern_replace bapr_checker u_bapr_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_if.valid),
  .in_ready      (in_if.ready),
  .in_last       (in_if.in_last),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .out_byte      (out_if.out_byte),
  .out_last      (out_if.out_last),
  .replace_count (out_if.replace_count)
);

### test/bit_aligned_pattern_replace_checker.sv
// ----------------------------------------------------------------------------
// bit_aligned_pattern_replace_checker: scoreboard for the pattern replacer
// Follows register writes and input transfers, predicts every output byte with
// its last mark and replacement count, and compares each output transfer
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module bit_aligned_pattern_replace_checker import bapr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  bapr_in_if                in_ch,
  bapr_out_if               out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [REG_W-1:0]  pwdata,
  input  logic              pready,
  output int                errors,
  output int                pending,
  output int                beats_checked,
  output int                streams_seen,
  output longint            replacements_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned HIT_LIMIT = (64'd1 << COUNT_BITS) - 1;
  localparam int PRINT_LIMIT = 40;

  typedef struct packed {
    logic [7:0]      data;
    logic            last;
    logic [RC_W-1:0] count;
  } out_beat_t;

  // Register copies as the block sees them.
  logic [REG_W-1:0]     pat_reg;
  logic [REG_W-1:0]     rep_reg;
  logic [CFG_LEN_W-1:0] len_reg;

  // Stream state: held bytes oldest first, bit starts still covered by the
  // last replacement, and the replacement count of the current stream.
  logic [7:0]      held [SCAN_BYTES];
  int unsigned     held_count;
  int unsigned     skip_bits;
  longint unsigned stream_hits;

  out_beat_t predicted_beats [$];

  task automatic report(input string what);
    errors++;
    if (errors <= PRINT_LIMIT) $display("[%0t] error: %s", $time, what);
  endtask

  task automatic clear_stream();
    for (int i = 0; i < SCAN_BYTES; i++) held[i] = '0;
    held_count  = 0;
    skip_bits   = 0;
    stream_hits = 0;
  endtask

  function automatic bit pattern_at(input int off, input int unsigned n);
    logic [15:0] pair;
    for (int j = 0; j < n; j++) begin
      pair = {held[j+1], held[j]} >> off;
      if (pair[7:0] != pat_reg[8*j +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // The replacement is written bit for bit over the matched span, which
  // straddles two held bytes whenever the offset is not zero.
  task automatic overwrite_at(input int off, input int unsigned n);
    logic [15:0] pair;
    for (int j = 0; j < n; j++) begin
      pair = {held[j+1], held[j]};
      pair = (pair & ~(16'h00FF << off)) | (16'(rep_reg[8*j +: 8]) << off);
      held[j]   = pair[7:0];
      held[j+1] = pair[15:8];
    end
  endtask

  task automatic scan_oldest(input int unsigned n, input bit live);
    int unsigned need;
    for (int off = 0; off < 8; off++) begin
      need = (off == 0) ? n : n + 1;
      if (skip_bits > 0) begin
        skip_bits--;
      end else if (live && held_count >= need && pattern_at(off, n)) begin
        overwrite_at(off, n);
        if (stream_hits < HIT_LIMIT) stream_hits++;
        skip_bits = (8 * n - 1) & 7'h7F;
      end
    end
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic last);
    int unsigned n;
    bit          live;
    logic [63:0] keep;
    logic [7:0]  head;
    out_beat_t   beat;
    if (len_reg == 0) n = 1;
    else if (len_reg > MAX_PATTERN_BYTES) n = MAX_PATTERN_BYTES;
    else n = len_reg;
    keep = (n >= 8) ? '1 : ((64'd1 << (8 * n)) - 1);
    // Identical pattern and replacement disable matching entirely.
    live = ((pat_reg ^ rep_reg) & keep) != 0;
    if (held_count < SCAN_BYTES) begin
      held[held_count] = b;
      held_count++;
    end
    while (held_count > 0 && (last || held_count > n)) begin
      scan_oldest(n, live);
      head = held[0];
      for (int i = 0; i < SCAN_BYTES - 1; i++) held[i] = held[i+1];
      held[SCAN_BYTES-1] = '0;
      held_count--;
      beat.data  = head;
      beat.last  = last && held_count == 0;
      beat.count = '0;
      if (beat.last) beat.count = (stream_hits > 16'hFFFF) ? 16'hFFFF : 16'(stream_hits);
      predicted_beats.push_back(beat);
    end
    if (last) begin
      clear_stream();
      streams_seen++;
    end
  endtask

  task automatic check_beat();
    out_beat_t want;
    if (predicted_beats.size() == 0) begin
      report($sformatf("output transfer %0d (byte %02h) with nothing predicted",
                       beats_checked, out_ch.out_byte));
    end else begin
      want = predicted_beats.pop_front();
      if (out_ch.out_byte !== want.data)
        report($sformatf("output transfer %0d: out_byte %02h, predicted %02h",
                         beats_checked, out_ch.out_byte, want.data));
      if (out_ch.out_last !== want.last)
        report($sformatf("output transfer %0d: out_last %b, predicted %b",
                         beats_checked, out_ch.out_last, want.last));
      if (out_ch.replace_count !== want.count)
        report($sformatf("output transfer %0d: replace_count %0d, predicted %0d",
                         beats_checked, out_ch.replace_count, want.count));
    end
    if (out_ch.out_last === 1'b1) replacements_seen += out_ch.replace_count;
    beats_checked++;
  endtask

  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [REG_W-1:0] value);
    case (reg_idx_t'(addr[ADDR_W-1:3]))
      REG_PATTERN: pat_reg = value;
      REG_REPLACE: rep_reg = value;
      REG_LENGTH:  len_reg = value[CFG_LEN_W-1:0];
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_stream();
      predicted_beats.delete();
      pat_reg = '0;
      rep_reg = '0;
      len_reg = CFG_LEN_W'(1);
    end else begin
      if (out_ch.valid && out_ch.ready) check_beat();
      if (in_ch.valid && in_ch.ready) predict_byte(in_ch.in_byte, in_ch.in_last);
      if (psel && penable && pwrite && pready) write_reg(paddr, pwdata);
    end
    pending = predicted_beats.size();
  end

endmodule

### test/bit_aligned_pattern_replace_tb.sv
// ----------------------------------------------------------------------------
// bit_aligned_pattern_replace_tb: top level of the pattern replacer testbench
// Resets the block, writes its registers over the APB port and feeds byte
// streams with directed cases, random settings and a long output hold-off;
// the checker scores the output.
// ----------------------------------------------------------------------------
module bit_aligned_pattern_replace_tb import bapr_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_THIRD} rx_mode_t;

  localparam int RANDOM_ITEMS = 400;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_CYCLES = 12;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [REG_W-1:0]  pwdata;
  logic [REG_W-1:0]  prdata;
  logic              pready;

  int     chk_errors;
  int     chk_pending;
  int     chk_beats;
  int     chk_streams;
  longint chk_hits;

  int items_sent  = 0;
  int burst_left  = 0;
  bit steady_flow = 1'b0;
  bit hold_req    = 1'b0;

  bapr_in_if  in_ch();
  bapr_out_if out_ch();

  always #1 clk = ~clk;

  bit_aligned_pattern_replace u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  bit_aligned_pattern_replace_checker u_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_ch             (in_ch),
    .out_ch            (out_ch),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .pready            (pready),
    .errors            (chk_errors),
    .pending           (chk_pending),
    .beats_checked     (chk_beats),
    .streams_seen      (chk_streams),
    .replacements_seen (chk_hits)
  );

  task automatic push_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (!steady_flow && $urandom_range(0, 3) != 0) gap = $urandom_range(1, 8);
    end
    burst_left--;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.in_last <= last;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  // Drops valid, waits for every predicted byte, then gives the block time to
  // move bytes that are held without a pending output.
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (chk_pending != 0);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [REG_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 3'b000});
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic apply_setting(input logic [63:0] pat, input logic [63:0] rep,
                               input logic [3:0] len);
    cfg_write(REG_PATTERN, pat);
    cfg_write(REG_REPLACE, rep);
    cfg_write(REG_LENGTH, REG_W'(len));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic random_setting(input int phase, output logic [63:0] pat,
                                output int unsigned eff);
    logic [63:0] rep;
    logic [63:0] keep;
    logic [3:0]  len;
    int unsigned kind;
    // The first phases cover the length extremes, including values that clamp.
    case (phase)
      0: len = 4'd1;
      1: len = 4'd8;
      2: len = 4'd0;
      3: len = 4'd15;
      default: len = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                                  : 4'($urandom_range(1, 8));
    endcase
    eff  = (len == 0) ? 1 : ((len > 8) ? 8 : len);
    kind = $urandom_range(0, 4);
    pat  = {$urandom, $urandom};
    if (kind == 1) pat = '0;
    else if (kind == 2) pat = '1;
    else if (kind == 3) pat = {8{pat[7:0]}};
    keep = (eff == 8) ? '1 : ((64'd1 << (8 * eff)) - 1);
    kind = $urandom_range(0, 5);
    if (kind == 0) rep = pat;
    else if (kind == 1) rep = pat ^ ({$urandom, $urandom} & ~keep);
    else rep = {$urandom, $urandom};
    apply_setting(pat, rep, len);
  endtask

  // Random or dense background with copies of the pattern written in at random
  // bit positions, sometimes back to back.
  task automatic send_stream(input logic [63:0] pat, input int unsigned plen,
                             input int unsigned nbytes);
    logic [7:0]  sbuf [0:63];
    logic [7:0]  fill_byte;
    int unsigned style;
    int unsigned span;
    int unsigned pos;
    int unsigned copies;
    style     = $urandom_range(0, 3);
    fill_byte = (style == 1) ? pat[7:0] : ((style == 2) ? 8'hFF : 8'h00);
    for (int i = 0; i < nbytes; i++)
      sbuf[i] = (style == 0 || $urandom_range(0, 3) == 0) ? 8'($urandom) : fill_byte;
    span = 8 * plen;
    if (8 * nbytes >= span) begin
      copies = $urandom_range(0, 3);
      pos    = $urandom_range(0, 8 * nbytes - span);
      for (int c = 0; c < copies; c++) begin
        for (int b = 0; b < span; b++) sbuf[(pos + b) / 8][(pos + b) % 8] = pat[b];
        if ($urandom_range(0, 1) == 1 && pos + 2 * span <= 8 * nbytes) pos = pos + span;
        else pos = $urandom_range(0, 8 * nbytes - span);
      end
    end
    for (int i = 0; i < nbytes; i++) push_byte(sbuf[i], i == nbytes - 1);
  endtask

  // Output side: ready follows a changing pattern, with an optional long hold-off.
  initial begin
    rx_mode_t mode;
    int       mode_left;
    int       hold_left;
    int       cyc;
    mode         = RX_OPEN;
    mode_left    = 0;
    hold_left    = 0;
    cyc          = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (mode_left == 0) begin
        mode      = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 80);
      end
      mode_left--;
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (mode)
          RX_OPEN:   out_ch.ready <= 1'b1;
          RX_MOSTLY: out_ch.ready <= ($urandom_range(0, 3) != 0);
          RX_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default:   out_ch.ready <= (cyc % 3 == 0);
        endcase
      end
    end
  end

  initial begin
    #1_000_000;
    $display("bit_aligned_pattern_replace: mismatch");
    $finish;
  end

  initial begin
    logic [63:0] pat;
    logic [63:0] rep;
    logic [79:0] shifted;
    int unsigned eff;
    int          phase;
    int          start;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = '0;
    in_ch.in_last = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings have equal pattern and replacement: data pass untouched.
    push_byte(8'h5C, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
    settle();

    // One-byte pattern at offset zero and again straddling two bytes.
    pat = {$urandom, $urandom};
    pat[7:0] = 8'hA5;
    rep = {$urandom, $urandom};
    rep[7:0] = 8'h3C;
    apply_setting(pat, rep, 4'd1);
    push_byte(8'hA5, 1'b0);
    push_byte(8'h28, 1'b0);
    push_byte(8'h05, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b1);
    settle();

    // Full eight-byte pattern five bits into the stream.
    pat = 64'hFEDC_BA98_7654_3210;
    apply_setting(pat, {$urandom, $urandom}, 4'd8);
    shifted = 80'(pat) << 5;
    for (int i = 0; i < 10; i++) push_byte(shifted[8*i +: 8], i == 9);
    settle();

    // Length shrinks and then grows while bytes are still held.
    apply_setting(64'h0000_0000_0011_2233, 64'h0000_0000_0044_5566, 4'd3);
    push_byte(8'h33, 1'b0);
    push_byte(8'h22, 1'b0);
    push_byte(8'h11, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h02, 1'b0);
    settle();
    apply_setting(64'h0000_0000_0011_2233, 64'h0000_0000_0044_5566, 4'd1);
    push_byte(8'h33, 1'b0);
    settle();
    apply_setting(64'h0000_0000_0011_2233, 64'h0000_0000_0044_5566, 4'd8);
    push_byte(8'hAA, 1'b0);
    push_byte(8'h55, 1'b1);
    settle();

    phase = 0;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      random_setting(phase, pat, eff);
      if (phase == 5) begin
        // Output held off while input keeps coming, so the block backs up.
        steady_flow = 1'b1;
        hold_req    = 1'b1;
        send_stream(pat, eff, 60);
        steady_flow = 1'b0;
      end else begin
        repeat ($urandom_range(2, 5))
          send_stream(pat, eff, ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                             : $urandom_range(1, 14));
      end
      settle();
      phase++;
    end

    $display("Sent %0d input bytes in %0d streams over %0d random settings.",
             items_sent, chk_streams, phase);
    $display("Checked %0d output transfers carrying %0d replacements in total.",
             chk_beats, chk_hits);
    if (chk_errors == 0) begin
      $display("bit_aligned_pattern_replace: match");
    end else begin
      $display("bit_aligned_pattern_replace: mismatch");
    end
    $finish;
  end

endmodule

### sim.f
hdl/bapr_pkg.sv
hdl/bapr_in_if.sv
hdl/bapr_out_if.sv
hdl/bapr_cfg.sv
hdl/bapr_cell.sv
hdl/bapr_match.sv
hdl/bit_aligned_pattern_replace.sv
hdl/bapr_checker.sv
test/bit_aligned_pattern_replace_checker.sv
test/bit_aligned_pattern_replace_tb.sv
